[rtl/core/spct_pkg.sv]
// Package: shape kinds, widths and shared arithmetic for the shape pair collision test.
`default_nettype none
package spct_pkg;
	localparam int CoordW = 16;
	localparam int DW     = CoordW + 3;   // doubled coordinate and sums of two
	localparam int PW     = 2 * DW + 2;   // product of two differences
	localparam int QW     = 2 * PW + 4;   // product of two products
	localparam int HW     = PW / 2;       // half of a product, for split multiplies

	typedef enum logic [1:0] {
		KIND_POINT   = 2'd0,
		KIND_SEGMENT = 2'd1,
		KIND_CIRCLE  = 2'd2,
		KIND_BOX     = 2'd3
	} kind_t;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [DW-1:0]     dv_t;
	typedef logic signed [PW-1:0]     pv_t;
	typedef logic signed [QW-1:0]     qv_t;
	typedef logic signed [HW:0]       hv_t;   // one half of a product, sign bit added
	typedef logic signed [2*HW+1:0]   hp_t;   // product of two halves

	typedef struct packed {
		kind_t  ka;
		kind_t  kb;
		dv_t [3:0] a;    // doubled coordinates of the lower kind
		dv_t [3:0] b;
		dv_t [3:0] ah;   // raw values (half sizes in doubled units)
		dv_t [3:0] bh;
	} pair_t;

	// Four point pairs for one segment against one edge.
	typedef struct packed {
		dv_t x1, y1, x2, y2, x3, y3, x4, y4;
	} seg4_t;

	// Products of one segment-segment test.
	typedef struct packed {
		pv_t d, s, t, e1, e2, e3;
	} segp_t;

	function automatic pv_t mulp(input dv_t x, input dv_t y);
		return pv_t'(x) * pv_t'(y);
	endfunction

	function automatic hp_t mulh(input hv_t x, input hv_t y);
		return hp_t'(x) * hp_t'(y);
	endfunction

	function automatic segp_t seg_products(input seg4_t g);
		dv_t ax, ay, bx, by, cx, cy;
		segp_t p;
		ax = g.x3 - g.x1; ay = g.y3 - g.y1;
		bx = g.x4 - g.x1; by = g.y4 - g.y1;
		cx = g.x2 - g.x1; cy = g.y2 - g.y1;
		p.d  = mulp(ax, by) - mulp(ay, bx);
		p.s  = mulp(cx, by) - mulp(cy, bx);
		p.t  = mulp(ax, cy) - mulp(ay, cx);
		p.e1 = mulp(ax, bx) + mulp(ay, by);
		p.e2 = mulp(g.x3 - g.x2, g.x4 - g.x2) + mulp(g.y3 - g.y2, g.y4 - g.y2);
		p.e3 = mulp(g.x1 - g.x3, g.x2 - g.x3) + mulp(g.y1 - g.y3, g.y2 - g.y3);
		return p;
	endfunction

	function automatic logic seg_decide(input segp_t p);
		pv_t st;
		st = p.s + p.t;
		if (p.d < 0)
			return (p.s <= 0) && (p.t <= 0) && (st <= p.d);
		else if (p.d > 0)
			return (p.s >= 0) && (p.t >= 0) && (p.d <= st);
		return (p.e1 <= 0) || (p.e2 <= 0) || (p.e3 <= 0);
	endfunction
endpackage
`default_nettype wire

[rtl/core/spct_order.sv]
// Input stage: sign extension, doubling and ordering of the pair by kind.
`default_nettype none
module spct_order (
	input  wire spct_pkg::kind_t  kind_a,
	input  wire spct_pkg::coord_t ca0, ca1, ca2, ca3,
	input  wire spct_pkg::kind_t  kind_b,
	input  wire spct_pkg::coord_t cb0, cb1, cb2, cb3,
	output spct_pkg::pair_t       pair
);
	import spct_pkg::*;
	coord_t [3:0] ra, rb;
	dv_t [3:0] da, db, ha, hb;
	logic swap;

	always_comb begin
		ra = {ca3, ca2, ca1, ca0};
		rb = {cb3, cb2, cb1, cb0};
		for (int i = 0; i < 4; i++) begin
			ha[i] = dv_t'(ra[i]);
			hb[i] = dv_t'(rb[i]);
			da[i] = ha[i] <<< 1;
			db[i] = hb[i] <<< 1;
		end
		swap = kind_a > kind_b;
		pair.ka = swap ? kind_b : kind_a;
		pair.kb = swap ? kind_a : kind_b;
		pair.a  = swap ? db : da;
		pair.b  = swap ? da : db;
		pair.ah = swap ? hb : ha;
		pair.bh = swap ? ha : hb;
	end
endmodule
`default_nettype wire

[rtl/core/spct_core.sv]
// Pipelined arithmetic core: operands, first products, split second products and decision.
`default_nettype none
module spct_core (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             adv,
	input  wire             in_v,
	input  wire spct_pkg::pair_t pair,
	output logic            out_v,
	output logic            out_hit
);
	import spct_pkg::*;

	// stage 1: operands
	logic  v_s1;
	kind_t ka_s1, kb_s1;
	seg4_t [3:0] sg_s1;      // segment vs box edges, or vs segment in lane 0
	dv_t   [3:0] dx_s1, dy_s1; // distances from centre/points
	dv_t   r_s1, rs_s1, k_s1, l_s1, ox_s1, oy_s1, ex_s1, ey_s1;
	logic  pb_s1, cb_rect_s1, bb_s1;

	// stage 2: first products
	logic  v_s2;
	kind_t ka_s2, kb_s2;
	segp_t [3:0] sp_s2;
	pv_t   [3:0] d2_s2;
	pv_t   r2_s2, rs2_s2, kl_s2, n_s2, dot_s2, ed_s2;
	logic  pb_s2, cb_rect_s2, bb_s2;

	// stage 3: second products as half-width partial products
	logic  v_s3;
	kind_t ka_s3, kb_s3;
	logic  [3:0] sh_s3, lt_s3;
	logic  lts_s3, ltr_s3, dneg_s3, pb_s3, cb_rect_s3, bb_s3;
	hp_t   nn_hh_s3, nn_hl_s3, nn_ll_s3;
	hp_t   rk_hh_s3, rk_hl_s3, rk_lh_s3, rk_ll_s3;

	seg4_t [3:0] sg_c;
	dv_t   [3:0] dx_c, dy_c;
	dv_t   lx, hx, ly, hy, pdx, pdy;
	logic  pb_c, cr_c, bb_c;
	hv_t   nh_c, nl_c, rh_c, rl_c, klh_c, kll_c;
	qv_t   nn_c, rk_c;

	always_comb begin
		lx = pair.b[0] - pair.bh[2]; hx = pair.b[0] + pair.bh[2];
		ly = pair.b[1] - pair.bh[3]; hy = pair.b[1] + pair.bh[3];
		sg_c[0] = '{pair.a[0], pair.a[1], pair.a[2], pair.a[3], lx, ly, hx, ly};
		sg_c[1] = '{pair.a[0], pair.a[1], pair.a[2], pair.a[3], hx, ly, hx, hy};
		sg_c[2] = '{pair.a[0], pair.a[1], pair.a[2], pair.a[3], hx, hy, lx, hy};
		sg_c[3] = '{pair.a[0], pair.a[1], pair.a[2], pair.a[3], lx, hy, lx, ly};
		if (pair.kb == KIND_SEGMENT)
			sg_c[0] = '{pair.a[0], pair.a[1], pair.a[2], pair.a[3],
				pair.b[0], pair.b[1], pair.b[2], pair.b[3]};
		// distances: circle-box corners in lanes 0..3, segment ends in 0..1
		if (pair.ka == KIND_CIRCLE) begin
			dx_c = {hx - pair.a[0], lx - pair.a[0], hx - pair.a[0], lx - pair.a[0]};
			dy_c = {hy - pair.a[1], hy - pair.a[1], ly - pair.a[1], ly - pair.a[1]};
		end else begin
			dx_c = {dv_t'(0), dv_t'(0), pair.b[0] - pair.a[2], pair.b[0] - pair.a[0]};
			dy_c = {dv_t'(0), dv_t'(0), pair.b[1] - pair.a[3], pair.b[1] - pair.a[1]};
		end
		pdx = pair.a[0] - pair.b[0];
		pdy = pair.a[1] - pair.b[1];
		if (pair.ka == KIND_BOX) begin
			pb_c = 1'b0;
			bb_c = ((pdx < 0) ? -pdx : pdx) < pair.ah[2] + pair.bh[2]
				&& ((pdy < 0) ? -pdy : pdy) < pair.ah[3] + pair.bh[3];
		end else begin
			bb_c = 1'b0;
			pb_c = ((pdx < 0) ? -pdx : pdx) < pair.bh[2]
				&& ((pdy < 0) ? -pdy : pdy) < pair.bh[3];
		end
		cr_c = (lx < pair.a[0] && pair.a[0] < hx && ly - pair.a[2] < pair.a[1]
				&& pair.a[1] < hy + pair.a[2])
			|| (lx - pair.a[2] < pair.a[0] && pair.a[0] < hx + pair.a[2]
				&& ly < pair.a[1] && pair.a[1] < hy);
	end

	// split n, r^2 and k^2 + l^2 into a signed high half and an unsigned low half
	always_comb begin
		nh_c  = hv_t'($signed(n_s2[PW-1:HW]));
		nl_c  = hv_t'({1'b0, n_s2[HW-1:0]});
		rh_c  = hv_t'($signed(r2_s2[PW-1:HW]));
		rl_c  = hv_t'({1'b0, r2_s2[HW-1:0]});
		klh_c = hv_t'($signed(kl_s2[PW-1:HW]));
		kll_c = hv_t'({1'b0, kl_s2[HW-1:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; out_v <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v; v_s2 <= v_s1; v_s3 <= v_s2; out_v <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ka_s1 <= pair.ka; kb_s1 <= pair.kb;
			sg_s1 <= sg_c; dx_s1 <= dx_c; dy_s1 <= dy_c;
			r_s1 <= (pair.ka == KIND_CIRCLE) ? pair.a[2] : pair.b[2];
			rs_s1 <= pair.a[2] + pair.b[2];
			k_s1 <= pair.a[3] - pair.a[1];
			l_s1 <= pair.a[2] - pair.a[0];
			ox_s1 <= pair.b[0] - pair.a[0];
			oy_s1 <= pair.b[1] - pair.a[1];
			ex_s1 <= pair.a[2] - pair.b[0];
			ey_s1 <= pair.a[3] - pair.b[1];
			pb_s1 <= pb_c; cb_rect_s1 <= cr_c; bb_s1 <= bb_c;

			ka_s2 <= ka_s1; kb_s2 <= kb_s1;
			for (int i = 0; i < 4; i++) begin
				sp_s2[i] <= seg_products(sg_s1[i]);
				d2_s2[i] <= mulp(dx_s1[i], dx_s1[i]) + mulp(dy_s1[i], dy_s1[i]);
			end
			r2_s2  <= mulp(r_s1, r_s1);
			rs2_s2 <= mulp(rs_s1, rs_s1);
			kl_s2  <= mulp(k_s1, k_s1) + mulp(l_s1, l_s1);
			n_s2   <= mulp(k_s1, ox_s1) - mulp(l_s1, oy_s1);
			// (s-c).(e-c) with s-c = -(ox, oy)
			dot_s2 <= mulp(-ox_s1, ex_s1) + mulp(-oy_s1, ey_s1);
			ed_s2  <= mulp(ox_s1, ox_s1) + mulp(oy_s1, oy_s1);
			pb_s2 <= pb_s1; cb_rect_s2 <= cb_rect_s1; bb_s2 <= bb_s1;

			ka_s3 <= ka_s2; kb_s3 <= kb_s2;
			for (int i = 0; i < 4; i++) begin
				sh_s3[i] <= seg_decide(sp_s2[i]);
				lt_s3[i] <= d2_s2[i] < r2_s2;
			end
			lts_s3  <= ed_s2 < rs2_s2;
			ltr_s3  <= ed_s2 < r2_s2;
			dneg_s3 <= dot_s2 < 0;
			nn_hh_s3 <= mulh(nh_c, nh_c);
			nn_hl_s3 <= mulh(nh_c, nl_c);
			nn_ll_s3 <= mulh(nl_c, nl_c);
			rk_hh_s3 <= mulh(rh_c, klh_c);
			rk_hl_s3 <= mulh(rh_c, kll_c);
			rk_lh_s3 <= mulh(rl_c, klh_c);
			rk_ll_s3 <= mulh(rl_c, kll_c);
			pb_s3 <= pb_s2; cb_rect_s3 <= cb_rect_s2; bb_s3 <= bb_s2;
		end
	end

	logic hit_c;
	always_comb begin
		// recombine the partial products; the cross term of n^2 counts twice
		nn_c = (qv_t'(nn_hh_s3) <<< (2 * HW)) + (qv_t'(nn_hl_s3) <<< (HW + 1))
			+ qv_t'(nn_ll_s3);
		rk_c = (qv_t'(rk_hh_s3) <<< (2 * HW))
			+ ((qv_t'(rk_hl_s3) + qv_t'(rk_lh_s3)) <<< HW) + qv_t'(rk_ll_s3);
		hit_c = 1'b0;
		case ({ka_s3, kb_s3})
			{KIND_POINT, KIND_CIRCLE}:    hit_c = ltr_s3;
			{KIND_POINT, KIND_BOX}:       hit_c = pb_s3;
			{KIND_SEGMENT, KIND_SEGMENT}: hit_c = sh_s3[0];
			{KIND_SEGMENT, KIND_BOX}:     hit_c = |sh_s3;
			{KIND_SEGMENT, KIND_CIRCLE}:
				hit_c = lt_s3[0] || lt_s3[1] || ((nn_c < rk_c) && dneg_s3);
			{KIND_CIRCLE, KIND_CIRCLE}:   hit_c = lts_s3;
			{KIND_CIRCLE, KIND_BOX}:      hit_c = cb_rect_s3 || (|lt_s3);
			{KIND_BOX, KIND_BOX}:         hit_c = bb_s3;
			default:                      hit_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) out_hit <= hit_c;
	end
endmodule
`default_nettype wire

[rtl/core/shape_pair_collision_test_top.sv]
// Top level of the shape pair collision test.
`default_nettype none
// Streaming 2D collision tester. Each transaction on the input channel carries
// two shapes (point, segment, circle or centred box, signed Q12.4) and yields
// exactly one transaction on the output channel with the hit flag. The pipeline
// has four register stages (operand set-up, first products, half-width partial
// second products with comparisons, result after recombining the partials), and
// one pair is taken every cycle while the pipeline advances, which it does
// whenever the output register is empty or being taken.
// A stall downstream holds every stage in place.
module shape_pair_collision_test_top (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire [1:0]            kind_a,
	input  wire spct_pkg::coord_t a_coord0,
	input  wire spct_pkg::coord_t a_coord1,
	input  wire spct_pkg::coord_t a_coord2,
	input  wire spct_pkg::coord_t a_coord3,
	input  wire [1:0]            kind_b,
	input  wire spct_pkg::coord_t b_coord0,
	input  wire spct_pkg::coord_t b_coord1,
	input  wire spct_pkg::coord_t b_coord2,
	input  wire spct_pkg::coord_t b_coord3,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic                 hit
);
	import spct_pkg::*;
	pair_t pair;
	logic  adv;

	// advance the whole pipeline when the result register is free or leaving
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	spct_order u_order (
		.kind_a(kind_t'(kind_a)), .ca0(a_coord0), .ca1(a_coord1), .ca2(a_coord2),
		.ca3(a_coord3),
		.kind_b(kind_t'(kind_b)), .cb0(b_coord0), .cb1(b_coord1), .cb2(b_coord2),
		.cb3(b_coord3),
		.pair(pair)
	);

	spct_core u_core (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_v(in_valid), .pair(pair),
		.out_v(out_valid), .out_hit(hit)
	);

	// hold the result while the consumer stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit))
		else $error("result dropped during stall");
	// no transaction is taken while the output is blocked
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while stalled");
endmodule
`default_nettype wire

[test/shape_pair_collision_test_top_tb.sv]
// Self-checking testbench for the shape pair collision test top level.
`timescale 1ns / 100ps

module shape_pair_collision_test_top_tb;
	import spct_pkg::*;

	// Exact arithmetic: doubled Q12.4 products of products stay well inside 128 bits
	typedef logic signed [127:0] wint_t;

	typedef struct {
		kind_t  ka;
		kind_t  kb;
		coord_t a [4];
		coord_t b [4];
	} pair_req_t;

	// Queue of expected hit flags, oldest first
	class hit_scoreboard;
		bit hit_q[$];
		int mismatches;

		function void note_pair(bit expected_hit);
			hit_q.push_back(expected_hit);
		endfunction

		function void check_hit(bit actual_hit);
			bit expected_hit;
			if (hit_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: hit=%0b", actual_hit);
				return;
			end
			expected_hit = hit_q.pop_front();
			if (expected_hit !== actual_hit) begin
				mismatches++;
				if (mismatches <= 10)
					$display("hit mismatch: expected %0b, got %0b", expected_hit, actual_hit);
			end
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	logic   [1:0] kind_a, kind_b;
	coord_t a_coord0, a_coord1, a_coord2, a_coord3;
	coord_t b_coord0, b_coord1, b_coord2, b_coord3;
	logic   out_valid;
	logic   out_ready;
	logic   hit;

	hit_scoreboard sb;
	bit            stall_busy;

	shape_pair_collision_test_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind_a   (kind_a),
		.a_coord0 (a_coord0),
		.a_coord1 (a_coord1),
		.a_coord2 (a_coord2),
		.a_coord3 (a_coord3),
		.kind_b   (kind_b),
		.b_coord0 (b_coord0),
		.b_coord1 (b_coord1),
		.b_coord2 (b_coord2),
		.b_coord3 (b_coord3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit      (hit)
	);

	// ---------------------------------------------------------------- predictor

	function automatic wint_t cross2(wint_t ax, wint_t ay, wint_t bx, wint_t by);
		return ax * by - ay * bx;
	endfunction

	function automatic wint_t dot2(wint_t ax, wint_t ay, wint_t bx, wint_t by);
		return ax * bx + ay * by;
	endfunction

	function automatic wint_t sq_dist(wint_t x1, wint_t y1, wint_t x2, wint_t y2);
		return dot2(x2 - x1, y2 - y1, x2 - x1, y2 - y1);
	endfunction

	function automatic wint_t abs_w(wint_t v);
		return (v < 0) ? -v : v;
	endfunction

	// Segment p1-p2 against segment p3-p4; the division is folded into a
	// sign-dependent comparison, and the collinear case falls back to dot products
	function automatic bit segments_cross(wint_t x1, wint_t y1, wint_t x2, wint_t y2,
			wint_t x3, wint_t y3, wint_t x4, wint_t y4);
		wint_t d, s, t;
		d = cross2(x3 - x1, y3 - y1, x4 - x1, y4 - y1);
		if (d != 0) begin
			s = cross2(x2 - x1, y2 - y1, x4 - x1, y4 - y1);
			t = cross2(x3 - x1, y3 - y1, x2 - x1, y2 - y1);
			if (d < 0)
				return s <= 0 && t <= 0 && s + t <= d;
			return s >= 0 && t >= 0 && d <= s + t;
		end
		return dot2(x3 - x1, y3 - y1, x4 - x1, y4 - y1) <= 0
			|| dot2(x3 - x2, y3 - y2, x4 - x2, y4 - y2) <= 0
			|| dot2(x1 - x3, y1 - y3, x2 - x3, y2 - y3) <= 0;
	endfunction

	function automatic bit predict_hit(pair_req_t p);
		kind_t lo_k, hi_k;
		wint_t a [4], b [4], ah [4], bh [4];
		wint_t lx, hx, ly, hy, r2, k, l, n, rs, r;
		bit    swap;
		swap = p.ka > p.kb;
		lo_k = swap ? p.kb : p.ka;
		hi_k = swap ? p.ka : p.kb;
		for (int i = 0; i < 4; i++) begin
			ah[i] = swap ? wint_t'(p.b[i]) : wint_t'(p.a[i]);
			bh[i] = swap ? wint_t'(p.a[i]) : wint_t'(p.b[i]);
			a[i]  = 2 * ah[i];
			b[i]  = 2 * bh[i];
		end
		lx = b[0] - bh[2]; hx = b[0] + bh[2];
		ly = b[1] - bh[3]; hy = b[1] + bh[3];
		case ({lo_k, hi_k})
			{KIND_POINT, KIND_CIRCLE}:
				return sq_dist(a[0], a[1], b[0], b[1]) < b[2] * b[2];
			{KIND_POINT, KIND_BOX}:
				return abs_w(a[0] - b[0]) < bh[2] && abs_w(a[1] - b[1]) < bh[3];
			{KIND_SEGMENT, KIND_BOX}:
				return segments_cross(a[0], a[1], a[2], a[3], lx, ly, hx, ly)
					|| segments_cross(a[0], a[1], a[2], a[3], hx, ly, hx, hy)
					|| segments_cross(a[0], a[1], a[2], a[3], hx, hy, lx, hy)
					|| segments_cross(a[0], a[1], a[2], a[3], lx, hy, lx, ly);
			{KIND_SEGMENT, KIND_SEGMENT}:
				return segments_cross(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3]);
			{KIND_SEGMENT, KIND_CIRCLE}: begin
				r2 = b[2] * b[2];
				if (sq_dist(a[0], a[1], b[0], b[1]) < r2
						|| sq_dist(a[2], a[3], b[0], b[1]) < r2)
					return 1;
				k = a[3] - a[1];
				l = a[2] - a[0];
				n = k * (b[0] - a[0]) - l * (b[1] - a[1]);
				if (!(n * n < r2 * dot2(k, l, k, l)))
					return 0;
				return dot2(a[0] - b[0], a[1] - b[1], a[2] - b[0], a[3] - b[1]) < 0;
			end
			{KIND_CIRCLE, KIND_CIRCLE}: begin
				rs = a[2] + b[2];
				return sq_dist(a[0], a[1], b[0], b[1]) < rs * rs;
			end
			{KIND_CIRCLE, KIND_BOX}: begin
				r  = a[2];
				r2 = r * r;
				if (lx < a[0] && a[0] < hx && ly - r < a[1] && a[1] < hy + r)
					return 1;
				if (lx - r < a[0] && a[0] < hx + r && ly < a[1] && a[1] < hy)
					return 1;
				return sq_dist(a[0], a[1], lx, ly) < r2 || sq_dist(a[0], a[1], hx, ly) < r2
					|| sq_dist(a[0], a[1], lx, hy) < r2 || sq_dist(a[0], a[1], hx, hy) < r2;
			end
			{KIND_BOX, KIND_BOX}:
				return abs_w(a[0] - b[0]) < ah[2] + bh[2]
					&& abs_w(a[1] - b[1]) < ah[3] + bh[3];
			default:
				return 0;   // point with point or segment
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0:       return coord_t'($urandom);                          // full range
			1:       return coord_t'(int'($urandom_range(0, 128)) - 64);  // dense, many ties
			default: return coord_t'(int'($urandom_range(0, 1600)) - 800);
		endcase
	endfunction

	function automatic pair_req_t rand_pair();
		pair_req_t p;
		int        mode, sel;
		sel  = $urandom_range(0, 9);
		mode = (sel == 0) ? 0 : (sel < 5) ? 1 : 2;
		p.ka = kind_t'($urandom_range(0, 3));
		p.kb = kind_t'($urandom_range(0, 3));
		for (int i = 0; i < 4; i++) begin
			p.a[i] = rand_coord(mode);
			p.b[i] = rand_coord(mode);
		end
		// pull the second shape close to the first so overlaps are common
		if (mode != 0 && $urandom_range(0, 1)) begin
			p.b[0] = p.a[0] + coord_t'(int'($urandom_range(0, 64)) - 32);
			p.b[1] = p.a[1] + coord_t'(int'($urandom_range(0, 64)) - 32);
		end
		return p;
	endfunction

	function automatic pair_req_t make_pair(kind_t ka, int a0, int a1, int a2, int a3,
			kind_t kb, int b0, int b1, int b2, int b3);
		pair_req_t p;
		p.ka = ka; p.kb = kb;
		p.a[0] = coord_t'(a0); p.a[1] = coord_t'(a1);
		p.a[2] = coord_t'(a2); p.a[3] = coord_t'(a3);
		p.b[0] = coord_t'(b0); p.b[1] = coord_t'(b1);
		p.b[2] = coord_t'(b2); p.b[3] = coord_t'(b3);
		return p;
	endfunction

	// Present one pair and hold it until the block takes it; valid stays high
	task automatic send_pair(pair_req_t p);
		in_valid <= 1'b1;
		kind_a   <= p.ka;   kind_b   <= p.kb;
		a_coord0 <= p.a[0]; a_coord1 <= p.a[1]; a_coord2 <= p.a[2]; a_coord3 <= p.a[3];
		b_coord0 <= p.b[0]; b_coord1 <= p.b[1]; b_coord2 <= p.b[2]; b_coord3 <= p.b[3];
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_pair(predict_hit(p));
	endtask

	// Drop valid for a number of cycles between bursts
	task automatic idle_sender(int cycles);
		if (cycles == 0)
			return;
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- clock, reset, limit

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver: alternate between free-running stretches and stretches with
	// random stalls of varying density
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_busy <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				stall_busy <= ~stall_busy;
			out_ready <= stall_busy ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	// Check every result transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_hit(hit);
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		pair_req_t dir_q[$];
		int        burst, guard;
		sb       = new();
		arst_n   = 1'b0;
		in_valid = 1'b0;
		kind_a   = KIND_POINT; kind_b = KIND_POINT;
		a_coord0 = '0; a_coord1 = '0; a_coord2 = '0; a_coord3 = '0;
		b_coord0 = '0; b_coord1 = '0; b_coord2 = '0; b_coord3 = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: each kind pair, touching boundaries, collinear and parallel
		// segments, negative sizes, zero-size shapes and coordinate extremes
		dir_q.push_back(make_pair(KIND_POINT, 0, 0, 0, 0, KIND_POINT, 0, 0, 0, 0));
		dir_q.push_back(make_pair(KIND_SEGMENT, -10, 0, 10, 0, KIND_POINT, 0, 0, 5, 5));
		dir_q.push_back(make_pair(KIND_POINT, 3, 4, 0, 0, KIND_CIRCLE, 0, 0, 5, 0));
		dir_q.push_back(make_pair(KIND_CIRCLE, 0, 0, -6, 0, KIND_POINT, 3, 4, 0, 0));
		dir_q.push_back(make_pair(KIND_POINT, 5, 0, 0, 0, KIND_BOX, 0, 0, 10, 10));
		dir_q.push_back(make_pair(KIND_BOX, 0, 0, 11, 11, KIND_POINT, 5, -5, 0, 0));
		dir_q.push_back(make_pair(KIND_SEGMENT, -20, 0, 20, 0, KIND_BOX, 0, 0, 8, 8));
		dir_q.push_back(make_pair(KIND_SEGMENT, -1, -1, 1, 1, KIND_BOX, 0, 0, 20, 20));
		dir_q.push_back(make_pair(KIND_SEGMENT, 0, 0, 10, 10, KIND_SEGMENT, 0, 10, 10, 0));
		dir_q.push_back(make_pair(KIND_SEGMENT, 0, 0, 10, 0, KIND_SEGMENT, 10, 0, 20, 0));
		dir_q.push_back(make_pair(KIND_SEGMENT, 0, 0, 10, 0, KIND_SEGMENT, 11, 0, 20, 0));
		dir_q.push_back(make_pair(KIND_SEGMENT, 0, 0, 10, 0, KIND_SEGMENT, 0, 1, 10, 1));
		dir_q.push_back(make_pair(KIND_SEGMENT, 0, 0, 0, 0, KIND_SEGMENT, 0, 0, 0, 0));
		dir_q.push_back(make_pair(KIND_SEGMENT, -20, 3, 20, 3, KIND_CIRCLE, 0, 0, 4, 0));
		dir_q.push_back(make_pair(KIND_CIRCLE, 0, 0, 4, 0, KIND_SEGMENT, -20, 4, 20, 4));
		dir_q.push_back(make_pair(KIND_SEGMENT, 5, 3, 20, 3, KIND_CIRCLE, 0, 0, 4, 0));
		dir_q.push_back(make_pair(KIND_CIRCLE, 0, 0, 3, 0, KIND_CIRCLE, 7, 0, 4, 0));
		dir_q.push_back(make_pair(KIND_CIRCLE, 0, 0, -3, 0, KIND_CIRCLE, 6, 0, 4, 0));
		dir_q.push_back(make_pair(KIND_CIRCLE, 0, 0, 3, 0, KIND_BOX, 8, 8, 10, 10));
		dir_q.push_back(make_pair(KIND_BOX, 10, 10, 10, 10, KIND_CIRCLE, 0, 0, 7, 0));
		dir_q.push_back(make_pair(KIND_BOX, 0, 0, 10, 10, KIND_BOX, 10, 0, 10, 10));
		dir_q.push_back(make_pair(KIND_BOX, 0, 0, -10, 10, KIND_BOX, 1, 0, 10, 10));
		dir_q.push_back(make_pair(KIND_SEGMENT, -32768, -32768, 32767, 32767,
			KIND_SEGMENT, -32768, 32767, 32767, -32768));
		dir_q.push_back(make_pair(KIND_CIRCLE, -32768, 32767, 32767, -32768,
			KIND_BOX, 32767, -32768, -32768, 32767));
		dir_q.push_back(make_pair(KIND_SEGMENT, 32767, -32768, -32768, 32767,
			KIND_CIRCLE, -32768, -32768, -32768, 32767));
		foreach (dir_q[i])
			send_pair(dir_q[i]);

		// Random: bursts of random length, some back-to-back, then a gap
		for (int n = 0; n < 950; ) begin
			burst = $urandom_range(1, 24);
			for (int j = 0; j < burst && n < 950; j++, n++)
				send_pair(rand_pair());
			idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
		end
		in_valid <= 1'b0;

		// Drain, then let the pipeline settle for its latency and a margin
		guard = 0;
		while (sb.hit_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (sb.hit_q.size() != 0)
			sb.mismatches++;

		if (sb.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
